// ----- design/wpst_pkg.sv -----
// ----------------------------------------------------------------------------
// wpst_pkg
// Shared types, codes and helper functions of the radio PHY state tracker.
// ----------------------------------------------------------------------------
package wpst_pkg;

   localparam int TimeWidth  = 63;
   localparam int WideWidth  = 64;
   localparam int DurWidth   = 32;
   localparam int OpWidth    = 4;
   localparam int StateWidth = 3;
   localparam int MaxRecords = 3;
   localparam int CountWidth = $clog2(MaxRecords + 1);

   typedef enum logic [OpWidth-1:0] {
      OP_QUERY       = 4'd0,
      OP_TX_START    = 4'd1,
      OP_SYNC_START  = 4'd2,
      OP_SYNC_EXTEND = 4'd3,
      OP_SYNC_END    = 4'd4,
      OP_RX_START    = 4'd5,
      OP_RX_OK       = 4'd6,
      OP_RX_ERROR    = 4'd7,
      OP_RX_TO_SYNC  = 4'd8,
      OP_CCA         = 4'd9
   } wpst_op_type;

   typedef enum logic [StateWidth-1:0] {
      ST_IDLE = 3'd0,
      ST_CCA  = 3'd1,
      ST_TX   = 3'd2,
      ST_RX   = 3'd3,
      ST_SYNC = 3'd4
   } wpst_phy_type;

   typedef struct packed {
      logic [OpWidth-1:0]   opcode;
      logic [TimeWidth-1:0] now_time;
      logic [DurWidth-1:0]  duration;
   } wpst_item_type;

   typedef struct packed {
      logic [WideWidth-1:0] tx_end;
      logic [WideWidth-1:0] sync_end;
      logic [WideWidth-1:0] sync_start;
      logic [WideWidth-1:0] rx_end;
      logic [WideWidth-1:0] rx_start;
      logic [WideWidth-1:0] cca_end;
      logic [WideWidth-1:0] cca_start;
      logic [WideWidth-1:0] last_change;
      logic [WideWidth-1:0] last_log;
      logic                 syncing;
      logic                 receiving;
   } wpst_state_type;

   typedef struct packed {
      logic [TimeWidth-1:0] log_begin;
      logic [TimeWidth-1:0] log_length;
      wpst_phy_type         log_state;
   } wpst_rec_type;

   typedef struct packed {
      wpst_rec_type [MaxRecords-1:0] rec;
      logic [CountWidth-1:0]         count;
      wpst_phy_type                  current_state;
      logic [TimeWidth-1:0]          idle_delay;
      logic [TimeWidth-1:0]          state_age;
      logic                          illegal;
   } wpst_result_type;

   function automatic logic [WideWidth-1:0] max64(input logic [WideWidth-1:0] a,
                                                  input logic [WideWidth-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [TimeWidth-1:0] sat63(input logic [WideWidth-1:0] x);
      return x[WideWidth-1] ? {TimeWidth{1'b1}} : x[TimeWidth-1:0];
   endfunction

   function automatic wpst_phy_type state_of(input logic [WideWidth-1:0] tx_end,
                                             input logic [WideWidth-1:0] cca_end,
                                             input logic                 syncing,
                                             input logic                 receiving,
                                             input logic [WideWidth-1:0] now);
      wpst_phy_type s;
      if (tx_end > now) s = ST_TX;
      else if (syncing) s = ST_SYNC;
      else if (receiving) s = ST_RX;
      else if (cca_end > now) s = ST_CCA;
      else s = ST_IDLE;
      return s;
   endfunction

endpackage

// ----- design/wpst_req_if.sv -----
// ----------------------------------------------------------------------------
// wpst_req_if
// Event channel of the PHY state tracker: valid, ready and one event item.
// ----------------------------------------------------------------------------
interface wpst_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [62:0] now_time;
   logic [31:0] duration;

   modport source (output valid, opcode, now_time, duration, input ready);
   modport sink   (input valid, opcode, now_time, duration, output ready);
   modport monitor (input valid, ready, opcode, now_time, duration);
endinterface

// ----- design/wpst_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wpst_rsp_if
// Result channel of the PHY state tracker: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface wpst_rsp_if;
   logic        valid;
   logic        ready;
   logic        log_valid;
   logic [62:0] log_begin;
   logic [62:0] log_length;
   logic [2:0]  log_state;
   logic [2:0]  current_state;
   logic [62:0] idle_delay;
   logic [62:0] state_age;
   logic        illegal;
   logic        last;

   modport source (output valid, log_valid, log_begin, log_length, log_state,
                   current_state, idle_delay, state_age, illegal, last,
                   input ready);
   modport sink   (input valid, log_valid, log_begin, log_length, log_state,
                   current_state, idle_delay, state_age, illegal, last,
                   output ready);
   modport monitor (input valid, ready, log_valid, log_begin, log_length, log_state,
                    current_state, idle_delay, state_age, illegal, last);
endinterface

// ----- design/wpst_core.sv -----
// ----------------------------------------------------------------------------
// wpst_core
// Event evaluation: next tracker state and up to three interval records.
// ----------------------------------------------------------------------------
module wpst_core
   import wpst_pkg::*;
(
   input  wpst_item_type   item,
   input  wpst_state_type  st,
   output wpst_state_type  nx,
   output wpst_result_type res
);

   logic [WideWidth-1:0] now;
   logic [WideWidth-1:0] now_dur;
   logic [WideWidth-1:0] idle_from;
   logic [WideWidth-1:0] cca_began;
   logic                 cca_tail;
   wpst_phy_type         s_old;
   wpst_phy_type         s_norx;
   wpst_phy_type         cs;
   logic                 bad;
   logic                 lead_idle;
   logic                 lead_cca;
   logic                 lead_sync;
   logic                 lead_rx;
   logic                 tx_log;

   logic                 a_en;
   logic [WideWidth-1:0] a_start;
   logic                 a_fire;
   logic                 b_fire;
   logic                 c_fire;
   logic [WideWidth-1:0] a_end;
   wpst_phy_type         a_state;
   logic [WideWidth-1:0] a_begin;
   logic [WideWidth-1:0] b_begin;
   logic [WideWidth-1:0] c_begin;
   logic [WideWidth-1:0] ll_a;
   logic [WideWidth-1:0] ll_b;
   logic [WideWidth-1:0] ll_c;
   wpst_rec_type [MaxRecords-1:0] cand;
   logic [MaxRecords-1:0]         cand_fire;
   logic [WideWidth-1:0]          end_time;

   assign now       = {1'b0, item.now_time};
   assign now_dur   = now + {{(WideWidth-DurWidth){1'b0}}, item.duration};
   assign idle_from = max64(max64(st.cca_end, st.sync_end), st.tx_end);
   assign cca_began = max64(max64(st.sync_end, st.tx_end), st.cca_start);
   assign cca_tail  = (st.cca_end > st.sync_end) && (st.cca_end > st.tx_end);
   assign s_old     = state_of(st.tx_end, st.cca_end, st.syncing, st.receiving, now);
   assign s_norx    = state_of(st.tx_end, st.cca_end, st.syncing, 1'b0, now);

   // event decode and state update
   always_comb begin
      nx        = st;
      bad       = 1'b0;
      lead_idle = 1'b0;
      lead_cca  = 1'b0;
      lead_sync = 1'b0;
      lead_rx   = 1'b0;
      tx_log    = 1'b0;
      case (wpst_op_type'(item.opcode))
         OP_QUERY: begin
         end
         OP_TX_START: begin
            case (s_old)
               ST_SYNC: begin
                  lead_sync   = 1'b1;
                  nx.syncing  = 1'b0;
                  nx.sync_end = now;
               end
               ST_RX: begin
                  lead_rx      = 1'b1;
                  nx.receiving = 1'b0;
               end
               ST_CCA:  lead_cca  = 1'b1;
               ST_IDLE: lead_idle = 1'b1;
               default: bad       = 1'b1;
            endcase
            if (!bad) begin
               tx_log         = 1'b1;
               nx.last_change = now;
               nx.tx_end      = now_dur;
            end
         end
         OP_SYNC_START, OP_RX_TO_SYNC: begin
            if (wpst_op_type'(item.opcode) == OP_SYNC_START) begin
               lead_idle = (s_old == ST_IDLE);
               lead_cca  = (s_old == ST_CCA);
            end else begin
               lead_idle = (s_norx == ST_IDLE);
               lead_cca  = (s_norx == ST_CCA);
            end
            if (lead_idle || lead_cca) begin
               nx.sync_start  = now;
               nx.last_change = now;
               nx.syncing     = 1'b1;
               nx.sync_end    = now_dur;
               nx.receiving   = (wpst_op_type'(item.opcode) == OP_SYNC_START) ?
                                st.receiving : 1'b0;
            end else begin
               bad = 1'b1;
            end
         end
         OP_SYNC_EXTEND: begin
            if (s_old == ST_SYNC) nx.sync_end = now_dur;
            else bad = 1'b1;
         end
         OP_SYNC_END: begin
            if (s_old == ST_SYNC) begin
               lead_sync      = 1'b1;
               nx.last_change = now;
               nx.syncing     = 1'b0;
            end
         end
         OP_RX_START: begin
            lead_idle = (s_old == ST_IDLE);
            lead_cca  = (s_old == ST_CCA);
            if (lead_idle || lead_cca) begin
               nx.last_change = now;
               nx.receiving   = 1'b1;
               nx.rx_start    = now;
               nx.rx_end      = now_dur;
            end else begin
               bad = 1'b1;
            end
         end
         OP_RX_OK, OP_RX_ERROR: begin
            if (s_old == ST_RX) begin
               lead_rx      = 1'b1;
               nx.receiving = 1'b0;
            end else begin
               bad = 1'b1;
            end
         end
         OP_CCA: begin
            lead_idle    = (s_old == ST_IDLE);
            nx.cca_start = now;
            nx.cca_end   = max64(st.cca_end, now_dur);
         end
         default: bad = 1'b1;
      endcase

      // first interval: cca tail, cca, sync or rx
      a_en    = 1'b0;
      a_start = cca_began;
      a_end   = now;
      a_state = ST_CCA;
      if (lead_idle) begin
         a_en  = cca_tail;
         a_end = idle_from;
      end else if (lead_cca) begin
         a_en = 1'b1;
      end else if (lead_sync) begin
         a_en    = 1'b1;
         a_start = st.sync_start;
         a_state = ST_SYNC;
      end else if (lead_rx) begin
         a_en    = 1'b1;
         a_start = st.rx_start;
         a_state = ST_RX;
      end

      // interval chain, each begin raised to the last logged time
      a_begin = max64(a_start, st.last_log);
      a_fire  = a_en && (a_end > a_begin);
      ll_a    = a_fire ? a_end : st.last_log;
      b_begin = max64(idle_from, ll_a);
      b_fire  = lead_idle && (now > b_begin);
      ll_b    = b_fire ? now : ll_a;
      c_begin = max64(now, ll_b);
      c_fire  = tx_log && (now_dur > c_begin);
      ll_c    = c_fire ? now_dur : ll_b;
      nx.last_log = ll_c;
   end

   assign cand[0]   = '{log_begin: sat63(a_begin), log_length: sat63(a_end - a_begin),
                        log_state: a_state};
   assign cand[1]   = '{log_begin: sat63(b_begin), log_length: sat63(now - b_begin),
                        log_state: ST_IDLE};
   assign cand[2]   = '{log_begin: sat63(c_begin), log_length: sat63(now_dur - c_begin),
                        log_state: ST_TX};
   assign cand_fire = {c_fire, b_fire, a_fire};

   assign cs = state_of(nx.tx_end, nx.cca_end, nx.syncing, nx.receiving, now);

   always_comb begin
      case (cs)
         ST_SYNC: end_time = nx.sync_end;
         ST_RX:   end_time = nx.rx_end;
         ST_TX:   end_time = nx.tx_end;
         ST_CCA:  end_time = nx.cca_end;
         default: end_time = '0;
      endcase
   end

   // pack fired records to the front
   always_comb begin
      res.rec   = '0;
      res.count = '0;
      for (int k = 0; k < MaxRecords; k++) begin
         if (cand_fire[k]) begin
            res.rec[res.count] = cand[k];
            res.count = res.count + 1'b1;
         end
      end
      res.current_state = cs;
      res.idle_delay    = (cs != ST_IDLE && end_time > now) ? sat63(end_time - now) : '0;
      res.state_age     = (now > nx.last_change) ? sat63(now - nx.last_change) : '0;
      res.illegal       = bad;
   end

endmodule

// ----- design/wifi_phy_state_tracker.sv -----
// ----------------------------------------------------------------------------
// wifi_phy_state_tracker
// Radio PHY state tracker with interval logging, top level.
// ----------------------------------------------------------------------------
// Events enter through an input register, are evaluated in a single pass
// against the tracker state and land in a result register that holds up to
// three interval records plus the closing status. The first result is
// presented once the item has moved from the input register to the result
// register. The result register sends one item per cycle while ready is high,
// and an event has one to three results; single-result events flow at one per
// cycle unless stalled; the next event is taken while current results are sent.
module wifi_phy_state_tracker
   import wpst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wpst_req_if.sink   req_if,
   wpst_rsp_if.source rsp_if
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   wpst_item_type         in_ff;
   wpst_item_type         in_in;
   wpst_state_type        state_ff;
   wpst_state_type        state_in;
   wpst_state_type        state_nx;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   wpst_result_type       out_ff;
   wpst_result_type       out_in;
   wpst_result_type       core_res;
   logic [CountWidth-1:0] ptr_ff;
   logic [CountWidth-1:0] ptr_in;
   logic [CountWidth-1:0] last_ptr;
   logic                  out_last;
   logic                  out_take;
   logic                  fire;
   logic                  has_rec;

   wpst_core u_core (
      .item (in_ff),
      .st   (state_ff),
      .nx   (state_nx),
      .res  (core_res)
   );

   assign last_ptr = (out_ff.count == '0) ? '0 : out_ff.count - 1'b1;
   assign out_last = (ptr_ff == last_ptr);
   assign out_take = out_valid_ff && rsp_if.ready;
   assign fire     = in_valid_ff && (!out_valid_ff || (out_take && out_last));
   assign has_rec  = (ptr_ff < out_ff.count);

   assign req_if.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      ptr_in       = ptr_ff;
      if (out_take) begin
         if (out_last) out_valid_in = 1'b0;
         else ptr_in = ptr_ff + 1'b1;
      end
      if (fire) begin
         state_in     = state_nx;
         out_in       = core_res;
         out_valid_in = 1'b1;
         ptr_in       = '0;
         in_valid_in  = 1'b0;
      end
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
         in_in       = '{opcode: req_if.opcode, now_time: req_if.now_time,
                         duration: req_if.duration};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ptr_ff       <= ptr_in;
         state_ff     <= state_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.log_valid     = has_rec;
   assign rsp_if.log_begin     = has_rec ? out_ff.rec[ptr_ff].log_begin : '0;
   assign rsp_if.log_length    = has_rec ? out_ff.rec[ptr_ff].log_length : '0;
   assign rsp_if.log_state     = has_rec ? out_ff.rec[ptr_ff].log_state
                                         : ST_IDLE;
   assign rsp_if.current_state = out_last ? out_ff.current_state : ST_IDLE;
   assign rsp_if.idle_delay    = out_last ? out_ff.idle_delay : '0;
   assign rsp_if.state_age     = out_last ? out_ff.state_age : '0;
   assign rsp_if.illegal       = out_last && out_ff.illegal;
   assign rsp_if.last          = out_last;

endmodule

// ----- design/wpst_checker.sv -----
// ----------------------------------------------------------------------------
// wpst_checker
// Port-level checks of the PHY state tracker, bound to the top level.
// ----------------------------------------------------------------------------
module wpst_checker
   import wpst_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_log_valid,
   input logic [TimeWidth-1:0]  rsp_log_begin,
   input logic [TimeWidth-1:0]  rsp_log_length,
   input logic [StateWidth-1:0] rsp_current_state,
   input logic [TimeWidth-1:0]  rsp_idle_delay,
   input logic [TimeWidth-1:0]  rsp_state_age,
   input logic                  rsp_illegal,
   input logic                  rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_log_begin))
      else $error("stalled result dropped or changed");

   // status fields only on the closing item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_current_state == ST_IDLE &&
         rsp_idle_delay == '0 && rsp_state_age == '0 && !rsp_illegal)
      else $error("status on a non-final item");

   // an item without a record is the sole item of its event
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_log_valid |-> rsp_last && rsp_log_begin == '0 &&
         rsp_log_length == '0)
      else $error("empty record item not final or not clear");

   // illegal events log nothing
   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |-> !rsp_log_valid)
      else $error("illegal event logged an interval");

   // idle has no pending end
   a_idle_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_current_state == ST_IDLE |->
         rsp_idle_delay == '0)
      else $error("idle state with a delay");

endmodule

bind wifi_phy_state_tracker wpst_checker u_wpst_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_log_valid     (rsp_if.log_valid),
   .rsp_log_begin     (rsp_if.log_begin),
   .rsp_log_length    (rsp_if.log_length),
   .rsp_current_state (rsp_if.current_state),
   .rsp_idle_delay    (rsp_if.idle_delay),
   .rsp_state_age     (rsp_if.state_age),
   .rsp_illegal       (rsp_if.illegal),
   .rsp_last          (rsp_if.last)
);

// ----- tb/wifi_phy_state_tracker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_phy_state_tracker_test
// Self-checking testbench of the radio PHY state tracker. A table of events
// covers every opcode, illegal transitions and the extreme times. A random
// event stream follows, steered mostly by the tracked PHY state. Every
// interval record and closing status is checked against a behavioural
// tracker or, for typed table rows, the table. Both channels stall at random,
// and the result side holds off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module wifi_phy_state_tracker_test;
   import wpst_pkg::*;

   localparam int ClockHalf    = 5;
   localparam int RandomEvents = 284;
   localparam int TopEvents    = 12;
   localparam int StallLimit   = 2000;
   localparam int DrainCycles  = 20;
   localparam int ChokeAt      = 150;
   localparam int ChokeCycles  = 80;

   localparam logic [OpWidth-1:0]   OP_UNDEFINED = 4'd15;
   localparam logic [TimeWidth-1:0] TimeMax      = {TimeWidth{1'b1}};
   localparam logic [DurWidth-1:0]  DurMax       = {DurWidth{1'b1}};
   localparam logic [WideWidth-1:0] TopBase      = 64'h7FFF_FFFC_0000_0000;

   typedef struct {
      bit                   log_valid;
      logic [TimeWidth-1:0] log_begin;
      logic [TimeWidth-1:0] log_length;
      wpst_phy_type         log_state;
      wpst_phy_type         current_state;
      logic [TimeWidth-1:0] idle_delay;
      logic [TimeWidth-1:0] state_age;
      bit                   illegal;
      bit                   last;
   } phy_result_type;

   typedef struct {
      logic [OpWidth-1:0]   op;
      logic [TimeWidth-1:0] at;
      logic [DurWidth-1:0]  dur;
      bit                   typed;
      wpst_phy_type         st;
      logic [TimeWidth-1:0] delay;
      logic [TimeWidth-1:0] age;
      bit                   bad;
   } event_row_type;

   // typed rows expect one status item without a record
   event_row_type event_table [26] = '{
      '{OP_QUERY,       63'd0,    32'd0,    1'b1, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_RX_OK,       63'd100,  32'd0,    1'b1, ST_IDLE, 63'd0,   63'd100, 1'b1},
      '{OP_SYNC_EXTEND, 63'd100,  32'd5,    1'b1, ST_IDLE, 63'd0,   63'd100, 1'b1},
      '{OP_UNDEFINED,   63'd200,  32'd0,    1'b1, ST_IDLE, 63'd0,   63'd200, 1'b1},
      '{OP_SYNC_END,    63'd200,  32'd0,    1'b1, ST_IDLE, 63'd0,   63'd200, 1'b0},
      '{OP_QUERY,       TimeMax,  DurMax,   1'b1, ST_IDLE, 63'd0,   TimeMax, 1'b0},
      '{OP_RX_ERROR,    TimeMax,  32'd0,    1'b1, ST_IDLE, 63'd0,   TimeMax, 1'b1},
      '{OP_CCA,         63'd300,  32'd100,  1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_RX_START,    63'd350,  32'd500,  1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_SYNC_START,  63'd400,  32'd10,   1'b1, ST_RX,   63'd450, 63'd50,  1'b1},
      '{OP_RX_TO_SYNC,  63'd500,  32'd300,  1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_SYNC_EXTEND, 63'd600,  32'd400,  1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_TX_START,    63'd700,  32'd200,  1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_TX_START,    63'd750,  32'd10,   1'b1, ST_TX,   63'd150, 63'd50,  1'b1},
      '{OP_RX_START,    63'd800,  32'd10,   1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_CCA,         63'd850,  32'd1000, 1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_QUERY,       63'd1000, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_RX_TO_SYNC,  63'd1100, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_SYNC_END,    63'd1200, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_TX_START,    63'd2000, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_RX_START,    63'd3000, DurMax,   1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_RX_OK,       63'd3100, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_SYNC_START,  63'd3200, 32'd1000, 1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_QUERY,       63'd3300, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_SYNC_END,    63'd3400, 32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0},
      '{OP_QUERY,       63'd10,   32'd0,    1'b0, ST_IDLE, 63'd0,   63'd0,   1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   wpst_req_if req_bus ();
   wpst_rsp_if rsp_bus ();

   wifi_phy_state_tracker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   // tracked phy state
   logic [WideWidth-1:0] tx_end_at   = '0;
   logic [WideWidth-1:0] sync_from   = '0;
   logic [WideWidth-1:0] sync_end_at = '0;
   logic [WideWidth-1:0] rx_from     = '0;
   logic [WideWidth-1:0] rx_end_at   = '0;
   logic [WideWidth-1:0] cca_from    = '0;
   logic [WideWidth-1:0] cca_end_at  = '0;
   logic [WideWidth-1:0] changed_at  = '0;
   logic [WideWidth-1:0] logged_upto = '0;
   bit                   syncing     = 1'b0;
   bit                   receiving   = 1'b0;

   int                   rec_n;
   logic [WideWidth-1:0] rec_begin [MaxRecords];
   logic [WideWidth-1:0] rec_len   [MaxRecords];
   wpst_phy_type         rec_kind  [MaxRecords];

   phy_result_type rsp_due_q [$];
   int          error_count = 0;
   int          events_sent = 0;
   int          stall_cycles = 0;
   bit          choke_on = 1'b0;

   function automatic logic [WideWidth-1:0] later(input logic [WideWidth-1:0] a,
                                                  input logic [WideWidth-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [TimeWidth-1:0] clip63(input logic [WideWidth-1:0] x);
      return x[WideWidth-1] ? TimeMax : x[TimeWidth-1:0];
   endfunction

   function automatic wpst_phy_type phy_state_at(input logic [WideWidth-1:0] t);
      if (tx_end_at > t) return ST_TX;
      if (syncing) return ST_SYNC;
      if (receiving) return ST_RX;
      if (cca_end_at > t) return ST_CCA;
      return ST_IDLE;
   endfunction

   function automatic logic [WideWidth-1:0] busy_since();
      return later(later(sync_end_at, tx_end_at), cca_from);
   endfunction

   task automatic log_span(input logic [WideWidth-1:0] from, input logic [WideWidth-1:0] upto,
                           input wpst_phy_type kind);
      logic [WideWidth-1:0] b;
      b = later(from, logged_upto);
      if (upto > b) begin
         if (rec_n < MaxRecords) begin
            rec_begin[rec_n] = b;
            rec_len[rec_n] = upto - b;
            rec_kind[rec_n] = kind;
            rec_n++;
         end
         logged_upto = upto;
      end
   endtask

   task automatic log_idle_and_busy(input logic [WideWidth-1:0] now);
      logic [WideWidth-1:0] idle_from;
      idle_from = later(later(cca_end_at, sync_end_at), tx_end_at);
      if (cca_end_at > sync_end_at && cca_end_at > tx_end_at)
         log_span(busy_since(), idle_from, ST_CCA);
      log_span(idle_from, now, ST_IDLE);
   endtask

   // close the idle or cca stretch that a new activity interrupts
   task automatic close_quiet(input logic [WideWidth-1:0] now, input wpst_phy_type s);
      if (s == ST_IDLE) log_idle_and_busy(now);
      else log_span(busy_since(), now, ST_CCA);
   endtask

   task automatic enter_sync(input logic [WideWidth-1:0] now, input logic [WideWidth-1:0] d,
                             output bit ok);
      wpst_phy_type s;
      s = phy_state_at(now);
      ok = (s == ST_IDLE || s == ST_CCA);
      if (ok) begin
         close_quiet(now, s);
         sync_from = now;
         changed_at = now;
         syncing = 1'b1;
         sync_end_at = now + d;
      end
   endtask

   task automatic apply_phy_event(input logic [OpWidth-1:0] op, input logic [TimeWidth-1:0] at,
                                  input logic [DurWidth-1:0] dur);
      logic [WideWidth-1:0] now;
      logic [WideWidth-1:0] d;
      logic [WideWidth-1:0] fin;
      wpst_phy_type         s;
      wpst_phy_type         cs;
      bit                   bad;
      bit                   ok;
      bit                   kept;
      int                   n;
      int                   k;
      phy_result_type       r;
      now = {1'b0, at};
      d = {32'd0, dur};
      s = phy_state_at(now);
      bad = 1'b0;
      rec_n = 0;
      case (op)
         OP_QUERY: bad = 1'b0;
         OP_TX_START: begin
            if (s == ST_TX) begin
               bad = 1'b1;
            end else begin
               if (s == ST_SYNC) begin
                  syncing = 1'b0;
                  log_span(sync_from, now, ST_SYNC);
                  sync_end_at = now;
               end else if (s == ST_RX) begin
                  receiving = 1'b0;
                  log_span(rx_from, now, ST_RX);
               end else begin
                  close_quiet(now, s);
               end
               log_span(now, now + d, ST_TX);
               changed_at = now;
               tx_end_at = now + d;
            end
         end
         OP_SYNC_START: begin
            enter_sync(now, d, ok);
            bad = !ok;
         end
         OP_SYNC_EXTEND: begin
            if (s == ST_SYNC) sync_end_at = now + d;
            else bad = 1'b1;
         end
         OP_SYNC_END: begin
            if (s == ST_SYNC) begin
               log_span(sync_from, now, ST_SYNC);
               changed_at = now;
               syncing = 1'b0;
            end
         end
         OP_RX_START: begin
            if (s == ST_IDLE || s == ST_CCA) begin
               close_quiet(now, s);
               changed_at = now;
               receiving = 1'b1;
               rx_from = now;
               rx_end_at = now + d;
            end else begin
               bad = 1'b1;
            end
         end
         OP_RX_OK, OP_RX_ERROR: begin
            if (s == ST_RX) begin
               log_span(rx_from, now, ST_RX);
               receiving = 1'b0;
            end else begin
               bad = 1'b1;
            end
         end
         OP_RX_TO_SYNC: begin
            kept = receiving;
            receiving = 1'b0;
            enter_sync(now, d, ok);
            if (!ok) begin
               receiving = kept;
               bad = 1'b1;
            end
         end
         OP_CCA: begin
            if (s == ST_IDLE) log_idle_and_busy(now);
            cca_from = now;
            cca_end_at = later(cca_end_at, now + d);
         end
         default: bad = 1'b1;
      endcase

      cs = phy_state_at(now);
      case (cs)
         ST_SYNC: fin = sync_end_at;
         ST_RX:   fin = rx_end_at;
         ST_TX:   fin = tx_end_at;
         ST_CCA:  fin = cca_end_at;
         default: fin = '0;
      endcase
      n = (rec_n > 0) ? rec_n : 1;
      for (k = 0; k < n; k++) begin
         r.log_valid = (k < rec_n);
         r.log_begin = r.log_valid ? clip63(rec_begin[k]) : '0;
         r.log_length = r.log_valid ? clip63(rec_len[k]) : '0;
         r.log_state = r.log_valid ? rec_kind[k] : ST_IDLE;
         r.last = (k == n - 1);
         r.current_state = r.last ? cs : ST_IDLE;
         r.idle_delay = (r.last && fin > now) ? clip63(fin - now) : '0;
         r.state_age = (r.last && now > changed_at) ? clip63(now - changed_at) : '0;
         r.illegal = r.last && bad;
         rsp_due_q.insert(rsp_due_q.size(), r);
      end
   endtask

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic void check_field(input string name, input logic [WideWidth-1:0] want,
                                       input logic [WideWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // returns at the edge that accepts the item
   task automatic offer_event(input logic [OpWidth-1:0] op, input logic [TimeWidth-1:0] at,
                              input logic [DurWidth-1:0] dur, input bit quiet);
      int hold;
      hold = (choke_on || quiet) ? 0 : gap_len();
      if (hold > 0) begin
         req_bus.valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.now_time <= at;
      req_bus.duration <= dur;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      events_sent++;
   endtask

   initial begin
      logic [WideWidth-1:0] base;
      logic [TimeWidth-1:0] at;
      logic [DurWidth-1:0]  dur;
      logic [OpWidth-1:0]   op;
      wpst_phy_type         s;
      phy_result_type       typed_rsp;
      int                   n0;
      int                   roll;
      int                   idx;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.now_time = '0;
      req_bus.duration = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (event_table[row]) begin
         offer_event(event_table[row].op, event_table[row].at, event_table[row].dur, 1'b0);
         n0 = rsp_due_q.size();
         apply_phy_event(event_table[row].op, event_table[row].at, event_table[row].dur);
         if (event_table[row].typed) begin
            while (rsp_due_q.size() > n0) void'(rsp_due_q.pop_back());
            typed_rsp.log_valid = 1'b0;
            typed_rsp.log_begin = '0;
            typed_rsp.log_length = '0;
            typed_rsp.log_state = ST_IDLE;
            typed_rsp.current_state = event_table[row].st;
            typed_rsp.idle_delay = event_table[row].delay;
            typed_rsp.state_age = event_table[row].age;
            typed_rsp.illegal = event_table[row].bad;
            typed_rsp.last = 1'b1;
            rsp_due_q.insert(rsp_due_q.size(), typed_rsp);
         end
      end

      base = 64'd4000;
      for (idx = 0; idx < RandomEvents; idx++) begin
         // last few items run near the top of the time range
         if (idx == RandomEvents - TopEvents) base = TopBase;
         roll = $urandom_range(0, 99);
         if (roll < 65) base += 64'($urandom_range(1, 120));
         else if (roll < 90) base += 64'($urandom_range(120, 2500));
         else if (roll >= 97) base += 64'($urandom());
         if (base > {1'b0, TimeMax}) base = {1'b0, TimeMax};
         at = base[TimeWidth-1:0];
         if ($urandom_range(0, 39) == 0) at = at - 63'($urandom_range(1, 600));

         s = phy_state_at({1'b0, at});
         roll = $urandom_range(0, 9);
         if ($urandom_range(0, 99) < 12) begin
            op = 4'($urandom_range(0, 15));
         end else begin
            case (s)
               ST_IDLE, ST_CCA: begin
                  if (roll < 3) op = OP_SYNC_START;
                  else if (roll < 6) op = OP_RX_START;
                  else if (roll == 6) op = OP_TX_START;
                  else if (roll == 7) op = OP_CCA;
                  else if (roll == 8) op = OP_RX_TO_SYNC;
                  else op = OP_QUERY;
               end
               ST_SYNC: begin
                  if (roll < 3) op = OP_SYNC_END;
                  else if (roll < 5) op = OP_SYNC_EXTEND;
                  else if (roll == 5) op = OP_TX_START;
                  else if (roll == 6) op = OP_CCA;
                  else if (roll == 7) op = OP_RX_TO_SYNC;
                  else if (roll == 8) op = OP_RX_START;
                  else op = OP_QUERY;
               end
               ST_RX: begin
                  if (roll < 4) op = OP_RX_OK;
                  else if (roll < 6) op = OP_RX_ERROR;
                  else if (roll < 8) op = OP_RX_TO_SYNC;
                  else if (roll == 8) op = OP_TX_START;
                  else op = OP_CCA;
               end
               default: begin
                  if (roll < 4) op = OP_CCA;
                  else if (roll < 7) op = OP_QUERY;
                  else if (roll == 7) op = OP_TX_START;
                  else if (roll == 8) op = OP_SYNC_START;
                  else op = OP_RX_OK;
               end
            endcase
         end

         // long periods only where they leave no end time that blocks later states
         roll = $urandom_range(0, 99);
         if (roll < 20 && op inside {OP_RX_START, OP_QUERY, OP_RX_OK, OP_RX_ERROR})
            dur = $urandom();
         else if (roll < 85) dur = $urandom_range(1, 1500);
         else dur = $urandom_range(0, 20);

         offer_event(op, at, dur, idx >= 40 && idx < 80);
         apply_phy_event(op, at, dur);
      end
      req_bus.valid <= 1'b0;

      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      int hold;
      bit choked;
      choked = 1'b0;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!choked && events_sent >= ChokeAt) begin
            // long hold-off so the block backs up, then a stretch with no stalls
            choked = 1'b1;
            choke_on = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (ChokeCycles) @(posedge clock);
            choke_on = 1'b0;
            rsp_bus.ready <= 1'b1;
            repeat (100) @(posedge clock);
         end else begin
            hold = gap_len();
            if (hold > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      phy_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (rsp_due_q.size() == 0) begin
            $error("result item with nothing expected");
            error_count++;
         end else begin
            want = rsp_due_q.pop_front();
            check_field("log_valid", 64'(want.log_valid), 64'(rsp_bus.log_valid));
            check_field("log_begin", 64'(want.log_begin), 64'(rsp_bus.log_begin));
            check_field("log_length", 64'(want.log_length), 64'(rsp_bus.log_length));
            check_field("log_state", 64'(want.log_state), 64'(rsp_bus.log_state));
            check_field("current_state", 64'(want.current_state),
                        64'(rsp_bus.current_state));
            check_field("idle_delay", 64'(want.idle_delay), 64'(rsp_bus.idle_delay));
            check_field("state_age", 64'(want.state_age), 64'(rsp_bus.state_age));
            check_field("illegal", 64'(want.illegal), 64'(rsp_bus.illegal));
            check_field("last", 64'(want.last), 64'(rsp_bus.last));
         end
      end
   end

   // watchdog on cycles without any item moving
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == StallLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ----- wifi_phy_state_tracker.f -----
design/wpst_pkg.sv
design/wpst_req_if.sv
design/wpst_rsp_if.sv
design/wpst_core.sv
design/wifi_phy_state_tracker.sv
design/wpst_checker.sv
tb/wifi_phy_state_tracker_test.sv
